[design/rdmru_pkg.sv]
// ----------------------------------------------------------------------------
// rdmru_pkg: shared types and constants of the recent device MRU list
// Field widths, operation and status codes, sequencer states and the
// control bundle that the sequencer broadcasts to the slot cells.
// ----------------------------------------------------------------------------
package rdmru_pkg;

   // field widths
   localparam int ADDR_W   = 48;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 3;
   localparam int COUNT_W  = 4;
   localparam int CAP_W    = 4;

   // built-in list depth and capacity after reset
   localparam int               MAX_SLOTS_DEFAULT = 8;
   localparam logic [CAP_W-1:0] CAP_RESET         = 4'd8;

   // request operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TOUCH  = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_CAP_ZERO = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_SCAN,
      ST_APPLY,
      ST_RESPOND
   } state_type;

   // list update applied by every cell in the apply cycle
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_MOVE_FRONT,
      OP_INSERT,
      OP_REMOVE
   } cell_op_type;

   // control bundle from the sequencer to the cell chain
   typedef struct packed {
      logic        compare;
      logic        scan;
      cell_op_type op;
   } cell_ctrl_type;

endpackage

[design/rdmru_req_if.sv]
// ----------------------------------------------------------------------------
// rdmru_req_if: request channel of the recent device MRU list
// Valid/ready channel carrying the operation code and the device address.
// ----------------------------------------------------------------------------
interface rdmru_req_if;
   logic                             valid;
   logic                             ready;
   logic [rdmru_pkg::FUNC_W-1:0]     func;
   logic [rdmru_pkg::ADDR_W-1:0]     device_addr;

   modport source (output valid, output func, output device_addr, input ready);
   modport sink   (input valid, input func, input device_addr, output ready);
endinterface

[design/rdmru_rsp_if.sv]
// ----------------------------------------------------------------------------
// rdmru_rsp_if: response channel of the recent device MRU list
// Valid/ready channel carrying status, hit flag, hit slot and entry count.
// ----------------------------------------------------------------------------
interface rdmru_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rdmru_pkg::STATUS_W-1:0]   status;
   logic                             hit;
   logic [rdmru_pkg::SLOT_W-1:0]     hit_slot;
   logic [rdmru_pkg::COUNT_W-1:0]    entry_count;

   modport source (output valid, output status, output hit, output hit_slot,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input hit, input hit_slot,
                   input entry_count, output ready);
endinterface

[design/rdmru_csr_if.sv]
// ----------------------------------------------------------------------------
// rdmru_csr_if: capacity register write channel
// Valid/ready channel carrying the write data of the capacity register.
// ----------------------------------------------------------------------------
interface rdmru_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rdmru_pkg::CAP_W-1:0]   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[design/rdmru_cell.sv]
// ----------------------------------------------------------------------------
// rdmru_cell: one slot of the MRU list
// Holds one address, compares it against the request, forwards the
// first-match token to the next cell and shifts with its neighbors.
// ----------------------------------------------------------------------------
module rdmru_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rdmru_pkg::cell_ctrl_type       ctrl,
   input  logic [rdmru_pkg::ADDR_W-1:0]   addr,
   input  logic [rdmru_pkg::CAP_W-1:0]    cap,
   input  logic [rdmru_pkg::ADDR_W-1:0]   prev_addr,
   input  logic [rdmru_pkg::ADDR_W-1:0]   next_addr,
   input  logic                           next_in_cap,
   input  logic                           found_in,
   input  logic [IDX_W-1:0]               idx_in,
   output logic [rdmru_pkg::ADDR_W-1:0]   slot_addr,
   output logic                           in_cap,
   output logic                           found_out,
   output logic [IDX_W-1:0]               idx_out
);
   import rdmru_pkg::*;

   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic              match_ff;   // this slot holds the address
   logic              found_ff;   // a match exists in an earlier slot
   logic [IDX_W-1:0]  idx_ff;     // index of that earlier match

   // slot lies inside the active capacity
   assign in_cap = (int'(cap) > INDEX);

   // first-match token handed to the next cell
   assign found_out = found_ff | match_ff;
   assign idx_out   = found_ff ? idx_ff : IDX_W'(INDEX);
   assign slot_addr = slot_ff;

   // list update
   always_comb begin
      slot_in = slot_ff;
      case (ctrl.op)
         OP_MOVE_FRONT: begin
            // slots up to and including the hit take the one before
            if (!found_ff) slot_in = prev_addr;
         end
         OP_INSERT: begin
            if (in_cap) slot_in = prev_addr;
         end
         OP_REMOVE: begin
            // slots from the hit on close the gap; last active slot clears
            if ((found_ff || match_ff) && in_cap) begin
               slot_in = next_in_cap ? next_addr : '0;
            end
         end
         default: slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         match_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         if (ctrl.compare) begin
            match_ff <= (slot_ff == addr) && in_cap;
            found_ff <= 1'b0;
         end else if (ctrl.scan) begin
            found_ff <= found_in;
         end
      end
   end

   // payload of the token
   always_ff @(posedge clock) begin
      if (ctrl.scan) idx_ff <= idx_in;
   end

endmodule

[design/recent_device_mru_list_unit.sv]
// ----------------------------------------------------------------------------
// recent_device_mru_list_unit: most-recently-used list of device addresses
// Request/response front end, capacity register, sequencer and cell chain.
// ----------------------------------------------------------------------------
// One request is handled at a time: a new request is accepted only in idle,
// after the response to the last one has been taken with rsp ready.
// Each request passes through the compare, scan, apply and respond states,
// then returns to idle. In the scan the first-match token walks the cell
// chain one slot per cycle, through every slot; in the apply state every
// cell shifts at once. The slot table and entry count are cleared by reset,
// with no sweep. The capacity register may only be written while no request
// is in flight; its value is clamped to MAX_SLOTS when a request is accepted.
// ----------------------------------------------------------------------------
module recent_device_mru_list_unit #(
   parameter int MAX_SLOTS = rdmru_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   rdmru_req_if.sink     req_bus,
   rdmru_rsp_if.source   rsp_bus,
   rdmru_csr_if.sink     csr_bus
);
   import rdmru_pkg::*;

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CMP_W = 8;

   state_type         state_ff, state_in;
   logic [CAP_W-1:0]  capacity_ff;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   func_type          func_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [IDX_W-1:0]  scan_ff;
   logic [COUNT_W-1:0] live_ff, live_in;
   cell_ctrl_type     ctrl;
   logic              scan_done;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic                hit_ff, hit_in;
   logic [SLOT_W-1:0]   hit_slot_ff, hit_slot_in;

   // cell chain wiring
   logic [ADDR_W-1:0] slot_w  [MAX_SLOTS];
   logic              in_cap_w[MAX_SLOTS];
   logic              found_w [MAX_SLOTS];
   logic [IDX_W-1:0]  idx_w   [MAX_SLOTS];
   logic              hit_any;
   logic [IDX_W-1:0]  hit_idx;

   assign hit_any = found_w[MAX_SLOTS-1];
   assign hit_idx = idx_w[MAX_SLOTS-1];

   // capacity register
   assign csr_bus.ready = !reset;
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_bus.valid) begin
         capacity_ff <= csr_bus.data;
      end
   end

   // effective capacity, clamped to the built-in depth
   always_comb begin
      if (CMP_W'(capacity_ff) < CMP_W'(MAX_SLOTS)) cap_in = capacity_ff;
      else                                        cap_in = CAP_W'(MAX_SLOTS);
   end

   assign scan_done = (scan_ff == IDX_W'(MAX_SLOTS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_bus.valid) state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_SCAN;
         ST_SCAN:    if (scan_done) state_in = ST_APPLY;
         ST_APPLY:   state_in = ST_RESPOND;
         ST_RESPOND: if (rsp_bus.ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      ctrl.compare  = 1'b0;
      ctrl.scan     = 1'b0;
      ctrl.op       = OP_HOLD;
      unique case (state_ff)
         ST_IDLE:    req_bus.ready = !reset;
         ST_COMPARE: ctrl.compare  = 1'b1;
         ST_SCAN:    ctrl.scan     = 1'b1;
         ST_APPLY: begin
            case (func_ff)
               FUNC_TOUCH: begin
                  if (hit_any)                 ctrl.op = OP_MOVE_FRONT;
                  else if (cap_ff != '0)       ctrl.op = OP_INSERT;
               end
               FUNC_REMOVE: if (hit_any)      ctrl.op = OP_REMOVE;
               default:                        ctrl.op = OP_HOLD;
            endcase
         end
         ST_RESPOND: rsp_bus.valid = 1'b1;
         default:    req_bus.ready = 1'b0;
      endcase
   end

   // response fields and entry count, formed in the apply cycle
   always_comb begin
      status_in   = STATUS_OK;
      hit_in      = hit_any;
      hit_slot_in = hit_any ? SLOT_W'(hit_idx) : '0;
      live_in     = live_ff;
      case (func_ff)
         FUNC_TOUCH: begin
            if (!hit_any) begin
               if (cap_ff == '0)          status_in = STATUS_CAP_ZERO;
               else if (live_ff < cap_ff) live_in   = live_ff + 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (!hit_any)              status_in = STATUS_NOT_FOUND;
            else if (live_ff != '0)    live_in   = live_ff - 1'b1;
         end
         FUNC_LOOKUP: begin
            if (!hit_any) status_in = STATUS_NOT_FOUND;
         end
         default: begin
            hit_in      = 1'b0;
            hit_slot_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         live_ff  <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_APPLY) live_ff <= live_in;
         if (state_ff == ST_SCAN) scan_ff <= scan_ff + 1'b1;
         else                     scan_ff <= '0;
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         func_ff <= func_type'(req_bus.func);
         addr_ff <= req_bus.device_addr;
         cap_ff  <= cap_in;
      end
      if (state_ff == ST_APPLY) begin
         status_ff   <= status_in;
         hit_ff      <= hit_in;
         hit_slot_ff <= hit_slot_in;
      end
   end

   assign rsp_bus.status      = status_ff;
   assign rsp_bus.hit         = hit_ff;
   assign rsp_bus.hit_slot    = hit_slot_ff;
   assign rsp_bus.entry_count = live_ff;

   // chain of slot cells, slot 0 first
   for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
      logic [ADDR_W-1:0] prev_addr, next_addr;
      logic              next_in_cap, found_in;
      logic [IDX_W-1:0]  idx_in;

      if (g == 0) begin : g_head
         assign prev_addr = addr_ff;
         assign found_in  = 1'b0;
         assign idx_in    = '0;
      end else begin : g_body
         assign prev_addr = slot_w[g-1];
         assign found_in  = found_w[g-1];
         assign idx_in    = idx_w[g-1];
      end

      if (g == MAX_SLOTS - 1) begin : g_tail
         assign next_addr   = '0;
         assign next_in_cap = 1'b0;
      end else begin : g_mid
         assign next_addr   = slot_w[g+1];
         assign next_in_cap = in_cap_w[g+1];
      end

      rdmru_cell #(
         .INDEX (g),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .addr        (addr_ff),
         .cap         (cap_ff),
         .prev_addr   (prev_addr),
         .next_addr   (next_addr),
         .next_in_cap (next_in_cap),
         .found_in    (found_in),
         .idx_in      (idx_in),
         .slot_addr   (slot_w[g]),
         .in_cap      (in_cap_w[g]),
         .found_out   (found_w[g]),
         .idx_out     (idx_w[g])
      );
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the recent device MRU list
// A local mirror of the slot table, entry count and capacity predicts every
// response as its request is accepted. Responses are compared field by field
// in order. Directed list and capacity cases come first, then a receiver
// hold-off, then random traffic over several capacity settings with bursty
// requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
   import rdmru_pkg::*;

   localparam int LIST_DEPTH       = MAX_SLOTS_DEFAULT;
   localparam int RSP_LATENCY      = LIST_DEPTH + 3;
   localparam int LONG_HOLD_CYCLES = 300;
   // worst quiet stretch: long hold plus one request plus sender gap, many times over
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int ITEMS_PER_PHASE  = 100;
   localparam int POOL_SIZE        = 12;

   typedef struct packed {
      status_type         status;
      logic               hit;
      logic [SLOT_W-1:0]  hit_slot;
      logic [COUNT_W-1:0] entry_count;
   } mru_outcome_type;

   typedef enum logic [1:0] {
      SINK_FREE,
      SINK_RANDOM,
      SINK_SPARSE,
      SINK_MOSTLY
   } sink_mode_type;

   logic clock;
   logic reset;

   rdmru_req_if req_bus ();
   rdmru_rsp_if rsp_bus ();
   rdmru_csr_if csr_bus ();

   recent_device_mru_list_unit #(
      .MAX_SLOTS (LIST_DEPTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // mirror of the list state
   logic [ADDR_W-1:0]  mirror_slot [LIST_DEPTH];
   logic [COUNT_W-1:0] mirror_count;
   logic [CAP_W-1:0]   mirror_cap;

   mru_outcome_type   expected_outcomes [$];
   logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
   int unsigned       error_count;
   int unsigned       burst_left;
   bit                long_hold_request;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // apply one operation to the mirror and return the response it gives
   function automatic mru_outcome_type predict_mru_op(input func_type op,
                                                      input logic [ADDR_W-1:0] addr);
      mru_outcome_type res;
      int limit;
      int pos;
      int i;
      limit = (mirror_cap > LIST_DEPTH) ? LIST_DEPTH : int'(mirror_cap);
      pos   = limit;
      for (i = limit - 1; i >= 0; i--) begin
         if (mirror_slot[i] == addr) pos = i;
      end
      res.status   = STATUS_OK;
      res.hit      = (pos < limit);
      res.hit_slot = res.hit ? pos[SLOT_W-1:0] : '0;
      case (op)
         FUNC_TOUCH: begin
            if (res.hit) begin
               for (i = pos; i > 0; i--) mirror_slot[i] = mirror_slot[i-1];
               mirror_slot[0] = addr;
            end else if (limit == 0) begin
               res.status = STATUS_CAP_ZERO;
            end else begin
               for (i = limit - 1; i > 0; i--) mirror_slot[i] = mirror_slot[i-1];
               mirror_slot[0] = addr;
               if (mirror_count < limit) mirror_count++;
            end
         end
         FUNC_REMOVE: begin
            if (res.hit) begin
               for (i = pos; i + 1 < limit; i++) mirror_slot[i] = mirror_slot[i+1];
               mirror_slot[limit-1] = '0;
               if (mirror_count > 0) mirror_count--;
            end else begin
               res.status = STATUS_NOT_FOUND;
            end
         end
         FUNC_LOOKUP: begin
            if (!res.hit) res.status = STATUS_NOT_FOUND;
         end
         default: begin
            res.hit      = 1'b0;
            res.hit_slot = '0;
         end
      endcase
      res.entry_count = mirror_count;
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [31:0] upper;
      logic [31:0] lower;
      upper = $urandom();
      lower = $urandom();
      return {upper[15:0], lower};
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // offer one request in bursts with random gaps; return at the accepting edge
   task automatic send_item(input func_type op, input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.func        <= op;
      req_bus.device_addr <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_outcomes.push_back(predict_mru_op(op, addr));
   endtask

   // random operation, mostly on pooled addresses so the list sees hits
   task automatic send_random_item();
      int unsigned pick;
      func_type op;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = FUNC_TOUCH;
      else if (pick < 65) op = FUNC_REMOVE;
      else if (pick < 92) op = FUNC_LOOKUP;
      else                op = FUNC_NOP;
      pick = $urandom_range(0, 99);
      if (pick < 70)      addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 76) addr = '0;
      else if (pick < 78) addr = {ADDR_W{1'b1}};
      else                addr = rand_addr();
      send_item(op, addr);
   endtask

   task automatic wait_for_results();
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   // capacity changes only with no request in flight
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      wait_for_results();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      mirror_cap = value;
   endtask

   // move to front, insert with drop, remove, lookup, zero address, no-op
   task automatic test_list_operations();
      logic [ADDR_W-1:0] picks [8];
      int i;
      picks[0] = 48'h0000_0000_0001;
      picks[1] = 48'h8000_0000_0000;
      picks[2] = 48'hAAAA_AAAA_AAAA;
      picks[3] = 48'h5555_5555_5555;
      picks[4] = 48'h0000_FFFF_0000;
      picks[5] = 48'hFFFF_0000_FFFF;
      picks[6] = rand_addr();
      picks[7] = rand_addr();
      // cleared table: zero matches slot 0
      send_item(FUNC_LOOKUP, '0);
      send_item(FUNC_TOUCH, '0);
      send_item(FUNC_TOUCH, {ADDR_W{1'b1}});
      // fill past capacity; the all-ones entry drops off
      for (i = 0; i < 8; i++) send_item(FUNC_TOUCH, picks[i]);
      send_item(FUNC_TOUCH, picks[0]);
      send_item(FUNC_LOOKUP, picks[4]);
      send_item(FUNC_LOOKUP, {ADDR_W{1'b1}});
      send_item(FUNC_REMOVE, picks[3]);
      send_item(FUNC_REMOVE, picks[3]);
      // the cleared last slot matches zero
      send_item(FUNC_LOOKUP, '0);
      send_item(FUNC_REMOVE, '0);
      send_item(FUNC_NOP, picks[0]);
      send_item(FUNC_TOUCH, '0);
   endtask

   // zero capacity, clamp above the built-in depth, single slot, restore
   task automatic test_capacity_limits();
      logic [ADDR_W-1:0] addr;
      addr = rand_addr();
      write_capacity(4'd0);
      send_item(FUNC_TOUCH, addr);
      send_item(FUNC_REMOVE, addr);
      send_item(FUNC_LOOKUP, '0);
      send_item(FUNC_NOP, addr);
      write_capacity(4'd15);
      send_item(FUNC_TOUCH, addr);
      write_capacity(4'd1);
      send_item(FUNC_TOUCH, rand_addr());
      send_item(FUNC_LOOKUP, addr);
      write_capacity(4'd8);
      send_item(FUNC_LOOKUP, addr);
   endtask

   // receiver holds off while requests keep coming
   task automatic test_output_backpressure();
      int i;
      for (i = 0; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
      long_hold_request = 1'b1;
      for (i = 0; i < 24; i++) send_random_item();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      wait_for_results();
   endtask

   // random traffic across capacity settings, lowering and raising included
   task automatic test_random_traffic();
      logic [CAP_W-1:0] phase_cap [8];
      int p;
      int i;
      phase_cap[0] = 4'd8;
      phase_cap[1] = 4'd15;
      phase_cap[2] = 4'd3;
      phase_cap[3] = 4'd8;
      phase_cap[4] = 4'd1;
      phase_cap[5] = 4'd0;
      phase_cap[6] = 4'd5;
      phase_cap[7] = CAP_W'($urandom_range(0, 15));
      for (p = 0; p < 8; p++) begin
         write_capacity(phase_cap[p]);
         for (i = 0; i < POOL_SIZE; i++) begin
            if ($urandom_range(0, 2) == 0) addr_pool[i] = rand_addr();
         end
         for (i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
      end
   endtask

   // response ready: stall pattern of its own, plus one long hold on request
   initial begin : rsp_ready_driver
      sink_mode_type mode;
      int unsigned mode_left;
      int unsigned tick;
      mode      = SINK_FREE;
      mode_left = 0;
      tick      = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = sink_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            tick++;
            case (mode)
               SINK_FREE:   rsp_bus.ready <= 1'b1;
               SINK_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
               SINK_SPARSE: rsp_bus.ready <= (tick % 4 == 0);
               default:     rsp_bus.ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin : response_checker
      mru_outcome_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual status %0d count %0d",
                     $time, rsp_bus.status, rsp_bus.entry_count);
            error_count++;
         end else begin
            want = expected_outcomes.pop_front();
            compare_field("status", 8'(want.status), 8'(rsp_bus.status));
            compare_field("hit", 8'(want.hit), 8'(rsp_bus.hit));
            compare_field("hit_slot", 8'(want.hit_slot), 8'(rsp_bus.hit_slot));
            compare_field("entry_count", 8'(want.entry_count), 8'(rsp_bus.entry_count));
         end
      end
   end

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin : watchdog
      int unsigned quiet_cycles;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= FUNC_TOUCH;
      req_bus.device_addr <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.data        <= '0;
      for (int i = 0; i < LIST_DEPTH; i++) mirror_slot[i] = '0;
      mirror_count      = '0;
      mirror_cap        = CAP_RESET;
      error_count       = 0;
      burst_left        = 0;
      long_hold_request = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_list_operations();
      test_capacity_limits();
      test_output_backpressure();
      test_random_traffic();

      req_bus.valid <= 1'b0;
      wait_for_results();
      repeat (RSP_LATENCY + 4) @(posedge clock);
      if (error_count == 0 && expected_outcomes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
